// ----- sv/dfs_pkg.sv -----
`timescale 1ns / 1ps
package dfs_pkg;

    localparam int DFS_DIR_FRAC_BITS = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IOR_W      = 14;
    localparam int COLOR_W    = 16;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 144;
    localparam int M_TUSER_W  = 2;

    localparam logic [IOR_W-1:0]   IOR_RESET   = 14'd6144;
    localparam logic [IOR_W-1:0]   ETA_ONE     = 14'd4096;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 16'hFFFF;
    localparam logic [16:0]        PDF_ONE     = 17'h10000;
    localparam logic [23:0]        W_MAX       = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IOR,
        CFG_T_RED,
        CFG_T_GREEN,
        CFG_T_BLUE,
        CFG_R_RED,
        CFG_R_GREEN,
        CFG_R_BLUE
    } t_cfg_idx;

    typedef enum logic [M_TUSER_W-1:0] {
        EV_TIR,
        EV_REFRACT,
        EV_REFLECT
    } t_event;

    // clamp a direction component to [-one, one] and keep 16 bits
    function automatic logic [15:0] dir_sat(input logic signed [33:0] v,
                                            input logic signed [33:0] one);
        logic signed [33:0] r;
        if (v > one) begin
            r = one;
        end else if (v < -one) begin
            r = -one;
        end else begin
            r = v;
        end
        return r[15:0];
    endfunction

endpackage

// ----- sv/dfs_pipe.sv -----
`timescale 1ns / 1ps
module dfs_pipe #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_stage [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_stage[k] <= (k == 0) ? i_d : r_stage[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    assign o_q = r_stage[N-1];

endmodule

// ----- sv/dfs_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage; needs i_num < i_den << QW
module dfs_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    logic [DW+NW-1:0] w_ext;
    logic [DW-1:0]    r_rem [QW];
    logic [DW-1:0]    r_den [QW];
    logic [QW-1:0]    r_quo [QW];
    logic [QW-1:0]    r_low [QW];

    assign w_ext = {{DW{1'b0}}, i_num};

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_step
            logic [DW-1:0] w_rem_in;
            logic [DW-1:0] w_den_in;
            logic [QW-1:0] w_quo_in;
            logic [QW-1:0] w_low_in;
            logic [DW:0]   w_trial;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in = w_ext[QW +: DW];
                assign w_den_in = i_den;
                assign w_quo_in = '0;
                assign w_low_in = i_num[QW-1:0];
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_den_in = r_den[k-1];
                assign w_quo_in = r_quo[k-1];
                assign w_low_in = r_low[k-1];
            end

            assign w_trial = {w_rem_in, w_low_in[QW-1]};
            assign w_ge    = (w_trial >= {1'b0, w_den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? DW'(w_trial - {1'b0, w_den_in}) : w_trial[DW-1:0];
                    r_den[k] <= w_den_in;
                    r_quo[k] <= QW'({w_quo_in, w_ge});
                    r_low[k] <= w_low_in << 1;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW-1];

endmodule

// ----- sv/dfs_sqrt.sv -----
`timescale 1ns / 1ps
// floor square root, two radicand bits per stage
module dfs_sqrt #(
    parameter int RW = 31
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_rad,
    output logic [RW-1:0]   o_root
);
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rad  [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_step
            logic [RW+1:0]   w_rem_in;
            logic [RW-1:0]   w_root_in;
            logic [2*RW-1:0] w_rad_in;
            logic [RW+1:0]   w_trial;
            logic [RW+1:0]   w_test;
            logic            w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in  = '0;
                assign w_root_in = '0;
                assign w_rad_in  = i_rad;
            end else begin : g_next
                assign w_rem_in  = r_rem[k-1];
                assign w_root_in = r_root[k-1];
                assign w_rad_in  = r_rad[k-1];
            end

            assign w_trial = {w_rem_in[RW-1:0], w_rad_in[2*RW-1 -: 2]};
            assign w_test  = {w_root_in, 2'b01};
            assign w_ge    = (w_trial >= w_test);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= w_ge ? (w_trial - w_test) : w_trial;
                    r_root[k] <= RW'({w_root_in, w_ge});
                    r_rad[k]  <= w_rad_in << 2;
                end
            end
        end
    endgenerate

    assign o_root = r_root[RW-1];

endmodule

// ----- sv/dielectric_fresnel_sample.sv -----
`timescale 1ns / 1ps
// glass bsdf sampler: snell + fresnel choice of reflection or refraction per sample
// throughput: one sample per cycle unless the output stalls;
// the dividers and the square root are unrolled stages
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (synchronous, active low) clears the valid chain and loads register defaults
module dielectric_fresnel_sample #(
    parameter int DIR_FRAC_BITS = dfs_pkg::DFS_DIR_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_wr_en,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dfs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // sample in
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // out_dir_x, out_dir_y, out_dir_z, random_draw
    input  logic [dfs_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // result out
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // in_dir_x, in_dir_y, in_dir_z, sample_pdf, weight_red, weight_green, weight_blue, zeros
    output logic [dfs_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // event_kind
    output logic [dfs_pkg::M_TUSER_W-1:0]    o_m_axis_tuser
);
    import dfs_pkg::*;

    // stage depths of the long units
    localparam int ST_QW = 31;   // sin_t^2 and tangential divides
    localparam int SQ_RW = 31;   // cos_t square root
    localparam int FR_QW = 17;   // fresnel ratios
    localparam int TS_QW = 61;   // eta^2 scaling of the refracted weight
    localparam int WD_QW = 24;   // weight over cosine
    localparam int LAT   = 5 + ST_QW + 1 + SQ_RW + 2 + FR_QW + 3 + 2 + TS_QW + 1 + WD_QW;

    localparam int C_SHIFT = 30 - DIR_FRAC_BITS;
    localparam logic [31:0]        ONE_U = 32'd1 << DIR_FRAC_BITS;
    localparam logic signed [33:0] ONE_S = 34'sd1 <<< DIR_FRAC_BITS;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]        draw;
        logic               zneg;
        logic [13:0]        ei;
        logic [13:0]        et;
        logic [27:0]        ei2;
        logic [27:0]        et2;
        logic [30:0]        c30;
        logic [30:0]        s2;
        logic [30:0]        mx;     // numerator, then quotient after the divide
        logic [30:0]        my;
        logic               tir;
        logic [30:0]        ct30;
        logic [30:0]        ct;
        logic               dz1;
        logic               dz2;
        logic [16:0]        fr;
        logic [16:0]        keep;
        logic               refl;
        logic [2:0][32:0]   m;
        logic [2:0]         wsat;
    } t_side;

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

    // ---------------- config registers ----------------
    logic [IOR_W-1:0]   r_ior;
    logic [COLOR_W-1:0] r_t_red, r_t_green, r_t_blue;
    logic [COLOR_W-1:0] r_r_red, r_r_green, r_r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ior     <= IOR_RESET;
            r_t_red   <= COLOR_RESET;
            r_t_green <= COLOR_RESET;
            r_t_blue  <= COLOR_RESET;
            r_r_red   <= COLOR_RESET;
            r_r_green <= COLOR_RESET;
            r_r_blue  <= COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IOR:     r_ior     <= i_cfg_wdata[IOR_W-1:0];
                CFG_T_RED:   r_t_red   <= i_cfg_wdata;
                CFG_T_GREEN: r_t_green <= i_cfg_wdata;
                CFG_T_BLUE:  r_t_blue  <= i_cfg_wdata;
                CFG_R_RED:   r_r_red   <= i_cfg_wdata;
                CFG_R_GREEN: r_r_green <= i_cfg_wdata;
                CFG_R_BLUE:  r_r_blue  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [2:0][COLOR_W-1:0] w_tcol, w_rcol;
    assign w_tcol = {r_t_blue, r_t_green, r_t_red};
    assign w_rcol = {r_r_blue, r_r_green, r_r_red};

    // ---------------- flow control ----------------
    // every stage moves together; the output register frees the pipe once taken
    logic           w_adv;
    logic [LAT-1:0] r_vld;
    logic           r_out_vld;

    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[LAT-2:0], i_s_axis_tvalid};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    // ---------------- stage a: capture the transfer ----------------
    t_side r_sa, n_sa;
    always_comb begin
        n_sa      = r_sa;
        n_sa.x    = i_s_axis_tdata[15:0];
        n_sa.y    = i_s_axis_tdata[31:16];
        n_sa.z    = i_s_axis_tdata[47:32];
        n_sa.draw = i_s_axis_tdata[63:48];
    end

    // ---------------- stage b: side, etas, clamped cosine ----------------
    t_side       r_sb, n_sb;
    logic [15:0] r_ax, r_ay;
    logic [13:0] w_ior;
    logic [16:0] w_zmag;
    logic [31:0] w_c;

    always_comb begin
        w_ior     = (r_ior == '0) ? 14'd1 : r_ior;
        w_zmag    = mag16(r_sa.z);
        w_c       = (32'(w_zmag) > ONE_U) ? ONE_U : 32'(w_zmag);
        n_sb      = r_sa;
        n_sb.zneg = r_sa.z[15];
        n_sb.ei   = r_sa.z[15] ? w_ior : ETA_ONE;
        n_sb.et   = r_sa.z[15] ? ETA_ONE : w_ior;
        n_sb.c30  = 31'({31'b0, w_c} << C_SHIFT);
    end

    // ---------------- stage c: squares, tangential numerators ----------------
    t_side       r_sc, n_sc;
    logic [61:0] r_c30sq;
    always_comb begin
        n_sc     = r_sb;
        n_sc.ei2 = 28'(r_sb.ei) * 28'(r_sb.ei);
        n_sc.et2 = 28'(r_sb.et) * 28'(r_sb.et);
        n_sc.mx  = 31'(r_ax) * 31'(r_sb.ei) + 31'(r_sb.et[13:1]);
        n_sc.my  = 31'(r_ay) * 31'(r_sb.ei) + 31'(r_sb.et[13:1]);
    end

    // ---------------- stage d: sin_i^2 ----------------
    t_side r_sd, n_sd;
    always_comb begin
        n_sd    = r_sc;
        n_sd.s2 = 31'(32'h4000_0000 - 32'(r_c30sq[61:30]));
    end

    // ---------------- stage e: sin_t^2 numerator ----------------
    t_side       r_se;
    logic [58:0] r_num;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sa    <= n_sa;
            r_sb    <= n_sb;
            r_ax    <= 16'(mag16(r_sa.x));
            r_ay    <= 16'(mag16(r_sa.y));
            r_sc    <= n_sc;
            r_c30sq <= 62'(r_sb.c30) * 62'(r_sb.c30);
            r_sd    <= n_sd;
            r_se    <= r_sd;
            r_num   <= 59'(r_sd.s2) * 59'(r_sd.ei2);
        end
    end

    // ---------------- stage f: total internal reflection test and divides ----------------
    t_side             w_se_tir, w_sf;
    logic [ST_QW-1:0]  w_st2, w_qx, w_qy;

    always_comb begin
        w_se_tir     = r_se;
        w_se_tir.tir = (r_num > 59'({r_se.et2, 30'b0}));
    end

    dfs_pipe #(.W($bits(t_side)), .N(ST_QW)) u_pipe_f (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_se_tir), .o_q(w_sf)
    );
    dfs_div #(.NW(59), .DW(28), .QW(ST_QW)) u_div_st2 (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_num), .i_den(r_se.et2), .o_quo(w_st2)
    );
    dfs_div #(.NW(31), .DW(14), .QW(ST_QW)) u_div_tx (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_se.mx), .i_den(r_se.et), .o_quo(w_qx)
    );
    dfs_div #(.NW(31), .DW(14), .QW(ST_QW)) u_div_ty (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_se.my), .i_den(r_se.et), .o_quo(w_qy)
    );

    // ---------------- stage g: cos_t^2 radicand ----------------
    t_side       r_sg, n_sg;
    logic [61:0] r_sqin;
    always_comb begin
        n_sg    = w_sf;
        n_sg.mx = w_qx;
        n_sg.my = w_qy;
    end

    // ---------------- stage h: square root ----------------
    t_side       w_sh;
    logic [30:0] w_ct30, w_ct;

    dfs_pipe #(.W($bits(t_side)), .N(SQ_RW)) u_pipe_h (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_sg), .o_q(w_sh)
    );
    dfs_sqrt #(.RW(SQ_RW)) u_sqrt (
        .i_clk(i_clk), .i_en(w_adv), .i_rad(r_sqin), .o_root(w_ct30)
    );

    // cos_t back to direction precision, rounded
    generate
        if (DIR_FRAC_BITS >= 30) begin : g_ct_full
            assign w_ct = w_ct30;
        end else begin : g_ct_round
            assign w_ct = 31'((32'(w_ct30) + (32'd1 << (29 - DIR_FRAC_BITS)))
                              >> (30 - DIR_FRAC_BITS));
        end
    endgenerate

    // ---------------- stage i: fresnel products ----------------
    t_side       r_si, n_si;
    logic [44:0] r_pa1, r_pb1, r_pa2, r_pb2;
    always_comb begin
        n_si      = w_sh;
        n_si.ct30 = w_ct30;
        n_si.ct   = w_ct;
    end

    // ---------------- stage j: ratio numerators and denominators ----------------
    t_side       r_sj, n_sj;
    logic [45:0] w_d1, w_d2, r_d1, r_d2;
    logic [44:0] w_n1, w_n2;
    logic [61:0] r_nn1, r_nn2;
    always_comb begin
        w_d1     = 46'(r_pa1) + 46'(r_pb1);
        w_d2     = 46'(r_pa2) + 46'(r_pb2);
        w_n1     = (r_pa1 > r_pb1) ? (r_pa1 - r_pb1) : (r_pb1 - r_pa1);
        w_n2     = (r_pa2 > r_pb2) ? (r_pa2 - r_pb2) : (r_pb2 - r_pa2);
        n_sj     = r_si;
        n_sj.dz1 = (w_d1 == '0);
        n_sj.dz2 = (w_d2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sg   <= n_sg;
            r_sqin <= {1'b0, 31'(31'h4000_0000 - w_st2), 30'b0};
            r_si   <= n_si;
            r_pa1  <= 45'(w_sh.et) * 45'(w_sh.c30);
            r_pb1  <= 45'(w_sh.ei) * 45'(w_ct30);
            r_pa2  <= 45'(w_sh.ei) * 45'(w_sh.c30);
            r_pb2  <= 45'(w_sh.et) * 45'(w_ct30);
            r_sj   <= n_sj;
            r_d1   <= w_d1;
            r_d2   <= w_d2;
            r_nn1  <= {1'b0, w_n1, 16'b0} + 62'(w_d1[45:1]);
            r_nn2  <= {1'b0, w_n2, 16'b0} + 62'(w_d2[45:1]);
        end
    end

    // ---------------- stage k: fresnel ratio divides ----------------
    t_side            w_sk;
    logic [FR_QW-1:0] w_q1, w_q2;

    dfs_pipe #(.W($bits(t_side)), .N(FR_QW)) u_pipe_k (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_sj), .o_q(w_sk)
    );
    dfs_div #(.NW(62), .DW(46), .QW(FR_QW)) u_div_r1 (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_nn1), .i_den(r_d1), .o_quo(w_q1)
    );
    dfs_div #(.NW(62), .DW(46), .QW(FR_QW)) u_div_r2 (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_nn2), .i_den(r_d2), .o_quo(w_q2)
    );

    // ---------------- stages l, m, n: reflectance and event choice ----------------
    t_side       r_sl, r_sm, r_sn, n_sn;
    logic [16:0] r_r1, r_r2;
    logic [33:0] r_sq1, r_sq2;
    logic [34:0] w_fsum;
    logic [16:0] w_fr;

    always_comb begin
        w_fsum    = 35'(r_sq1) + 35'(r_sq2) + 35'(PDF_ONE);
        w_fr      = w_fsum[33:17];
        n_sn      = r_sm;
        n_sn.fr   = w_fr;
        n_sn.keep = PDF_ONE - w_fr;
        n_sn.refl = ({1'b0, r_sm.draw} < w_fr);
    end

    // ---------------- stage o: color times probability ----------------
    t_side       r_so, n_so;
    logic [16:0] w_pb;
    logic        w_use_r;
    always_comb begin
        n_so    = r_sn;
        w_pb    = r_sn.tir ? PDF_ONE : (r_sn.refl ? r_sn.fr : r_sn.keep);
        w_use_r = r_sn.refl && !r_sn.tir;
        for (int c = 0; c < 3; c++) begin
            n_so.m[c] = 33'(w_use_r ? w_rcol[c] : w_tcol[c]) * 33'(w_pb);
        end
    end

    // ---------------- stage p: eta_i^2 scaling numerator ----------------
    t_side             r_sp;
    logic [2:0][60:0]  r_qn;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sl  <= w_sk;
            r_r1  <= w_sk.dz1 ? PDF_ONE : w_q1;
            r_r2  <= w_sk.dz2 ? PDF_ONE : w_q2;
            r_sm  <= r_sl;
            r_sq1 <= 34'(r_r1) * 34'(r_r1);
            r_sq2 <= 34'(r_r2) * 34'(r_r2);
            r_sn  <= n_sn;
            r_so  <= n_so;
            r_sp  <= r_so;
            for (int c = 0; c < 3; c++) begin
                r_qn[c] <= 61'(r_so.m[c]) * 61'(r_so.ei2) + 61'(r_so.et2[27:1]);
            end
        end
    end

    // ---------------- stage q: divide by eta_t^2 ----------------
    t_side             w_sq;
    logic [2:0][60:0]  w_ts;

    dfs_pipe #(.W($bits(t_side)), .N(TS_QW)) u_pipe_q (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_sp), .o_q(w_sq)
    );

    genvar gc;
    generate
        for (gc = 0; gc < 3; gc++) begin : g_ts
            dfs_div #(.NW(61), .DW(28), .QW(TS_QW)) u_div_ts (
                .i_clk(i_clk), .i_en(w_adv), .i_num(r_qn[gc]), .i_den(r_sp.et2),
                .o_quo(w_ts[gc])
            );
        end
    endgenerate

    // ---------------- stage r: weight numerator, cosine, saturation ----------------
    t_side             r_sr, n_sr;
    logic              w_refr_q;
    logic [30:0]       w_wden, r_wden;
    logic [2:0][60:0]  w_wnum, r_wnum;

    always_comb begin
        w_refr_q = !w_sq.tir && !w_sq.refl;
        w_wden   = w_refr_q ? w_sq.ct30 : w_sq.c30;
        n_sr     = w_sq;
        for (int c = 0; c < 3; c++) begin
            w_wnum[c]    = w_refr_q ? w_ts[c] : 61'(w_sq.m[c]);
            n_sr.wsat[c] = (w_wden == '0) || (w_wnum[c] >= 61'({w_wden, 10'b0}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sr   <= n_sr;
            r_wnum <= w_wnum;
            r_wden <= w_wden;
        end
    end

    // ---------------- stage s: weight over cosine ----------------
    t_side             w_ss;
    logic [2:0][23:0]  w_wq;

    dfs_pipe #(.W($bits(t_side)), .N(WD_QW)) u_pipe_s (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_sr), .o_q(w_ss)
    );

    generate
        for (gc = 0; gc < 3; gc++) begin : g_wd
            dfs_div #(.NW(75), .DW(31), .QW(WD_QW)) u_div_wd (
                .i_clk(i_clk), .i_en(w_adv), .i_num({r_wnum[gc], 14'b0}), .i_den(r_wden),
                .o_quo(w_wq[gc])
            );
        end
    endgenerate

    // ---------------- stage t: result register ----------------
    logic             w_refr;
    logic [15:0]      n_dx, n_dy, n_dz;
    logic [16:0]      n_pdf;
    logic [2:0][23:0] n_w;
    t_event           n_kind;
    logic signed [33:0] w_mx, w_my, w_ct_s;

    logic [15:0]      r_dx, r_dy, r_dz;
    logic [16:0]      r_pdf;
    logic [2:0][23:0] r_w;
    t_event           r_kind;

    always_comb begin
        w_refr = !w_ss.tir && !w_ss.refl;
        w_mx   = (w_ss.s2 == '0) ? 34'sd0 :
                 (w_ss.x[15] ? $signed({3'b0, w_ss.mx}) : -$signed({3'b0, w_ss.mx}));
        w_my   = (w_ss.s2 == '0) ? 34'sd0 :
                 (w_ss.y[15] ? $signed({3'b0, w_ss.my}) : -$signed({3'b0, w_ss.my}));
        w_ct_s = w_ss.zneg ? $signed({3'b0, w_ss.ct}) : -$signed({3'b0, w_ss.ct});
        if (w_refr) begin
            n_dx = dir_sat(w_mx, ONE_S);
            n_dy = dir_sat(w_my, ONE_S);
            n_dz = dir_sat(w_ct_s, ONE_S);
        end else begin
            // mirror about the normal
            n_dx = dir_sat(-34'(w_ss.x), ONE_S);
            n_dy = dir_sat(-34'(w_ss.y), ONE_S);
            n_dz = dir_sat(34'(w_ss.z), ONE_S);
        end
        if (w_ss.tir) begin
            n_kind = EV_TIR;
            n_pdf  = PDF_ONE;
        end else if (w_ss.refl) begin
            n_kind = EV_REFLECT;
            n_pdf  = w_ss.fr;
        end else begin
            n_kind = EV_REFRACT;
            n_pdf  = w_ss.keep;
        end
        for (int c = 0; c < 3; c++) begin
            n_w[c] = w_ss.wsat[c] ? W_MAX : w_wq[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_dz   <= n_dz;
            r_pdf  <= n_pdf;
            r_w    <= n_w;
            r_kind <= n_kind;
        end
    end

    assign o_m_axis_tdata = {7'b0, r_w[2], r_w[1], r_w[0], r_pdf, r_dz, r_dy, r_dx};
    assign o_m_axis_tuser = r_kind;

endmodule
